/* sv/sorted_key_table_assert.svh */
// ----------------------------------------------------------------------------
// sorted_key_table_assert.svh - assertion macros
// Shorthands for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_ASSERT_SVH
`define SORTED_KEY_TABLE_ASSERT_SVH

// same-cycle implication
`define SKT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SKT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/skt_pkg.sv */
// ----------------------------------------------------------------------------
// skt_pkg - sorted key table package
// Item types, request kinds and status codes.
// ----------------------------------------------------------------------------
package skt_pkg;

  typedef logic [2:0]  kind_t;
  typedef logic [63:0] key_t;
  typedef logic [31:0] pay_t;
  typedef logic [4:0]  pos_t;
  typedef logic [1:0]  status_t;
  typedef logic [5:0]  count_t;

  localparam int POS_W = 5;

  localparam kind_t KIND_CLEAR     = 3'd0;
  localparam kind_t KIND_INSERT    = 3'd1;
  localparam kind_t KIND_FIND      = 3'd2;
  localparam kind_t KIND_READ      = 3'd3;
  localparam kind_t KIND_OVERWRITE = 3'd4;
  localparam kind_t KIND_DELETE    = 3'd5;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_FULL   = 2'd1;
  localparam status_t ST_MISS   = 2'd2;
  localparam status_t ST_BADPOS = 2'd3;

  typedef struct packed {
    kind_t kind;
    key_t  name_key;
    pay_t  entry_payload;
    pos_t  position;
  } in_item_t;

  typedef struct packed {
    status_t status;
    pos_t    found_position;
    key_t    read_key;
    pay_t    read_payload;
    count_t  entry_count;
  } out_item_t;

endpackage

/* sv/skt_mem.sv */
// ----------------------------------------------------------------------------
// skt_mem - entry storage
// One write port, one read port with registered read data, key and payload.
// ----------------------------------------------------------------------------
module skt_mem #(
  parameter int DEPTH        = 32,
  parameter int KEY_BITS     = 64,
  parameter int PAYLOAD_BITS = 32,
  localparam int AW          = $clog2(DEPTH)
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AW-1:0]           waddr_i,
  input  logic [KEY_BITS-1:0]     wkey_i,
  input  logic [PAYLOAD_BITS-1:0] wpay_i,
  input  logic                    re_i,
  input  logic [AW-1:0]           raddr_i,
  output logic [KEY_BITS-1:0]     rkey_o,
  output logic [PAYLOAD_BITS-1:0] rpay_o
);

  logic [KEY_BITS-1:0]     key_mem [DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_mem [DEPTH];
  logic [KEY_BITS-1:0]     rkey_q;
  logic [PAYLOAD_BITS-1:0] rpay_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[waddr_i] <= wkey_i;
      pay_mem[waddr_i] <= wpay_i;
    end
    if (re_i) begin
      rkey_q <= key_mem[raddr_i];
      rpay_q <= pay_mem[raddr_i];
    end
  end

  assign rkey_o = rkey_q;
  assign rpay_o = rpay_q;

endmodule

/* sv/skt_ctrl.sv */
// ----------------------------------------------------------------------------
// skt_ctrl - sorted key table sequencer
// Walks the entry memory one entry per cycle through a shared key comparator
// to insert, find, read, overwrite and delete; clear resets the entry count.
// ----------------------------------------------------------------------------
`include "sorted_key_table_assert.svh"

module skt_ctrl #(
  parameter int DEPTH        = 32,
  parameter int KEY_BITS     = 64,
  parameter int PAYLOAD_BITS = 32,
  localparam int AW          = $clog2(DEPTH),
  localparam int CW          = $clog2(DEPTH + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    req_valid_i,
  output logic                    req_ready_o,
  input  skt_pkg::in_item_t       req_i,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output skt_pkg::out_item_t      res_o,
  output logic                    mem_we_o,
  output logic [AW-1:0]           mem_waddr_o,
  output logic [KEY_BITS-1:0]     mem_wkey_o,
  output logic [PAYLOAD_BITS-1:0] mem_wpay_o,
  output logic                    mem_re_o,
  output logic [AW-1:0]           mem_raddr_o,
  input  logic [KEY_BITS-1:0]     mem_rkey_i,
  input  logic [PAYLOAD_BITS-1:0] mem_rpay_i
);

  localparam int XW   = CW + 1;
  localparam int CMPW = (CW > skt_pkg::POS_W) ? CW : skt_pkg::POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_CMP,
    S_INS_PUT,
    S_FIND_CMP,
    S_READ_WAIT,
    S_DEL_MOVE,
    S_RESULT
  } state_e;

  state_e                  state_q, state_d;
  skt_pkg::kind_t          kind_q, kind_d;
  logic [KEY_BITS-1:0]     key_q, key_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;
  skt_pkg::pos_t           pos_q, pos_d;
  logic [AW-1:0]           idx_q, idx_d;
  logic [CW-1:0]           count_q, count_d;
  skt_pkg::status_t        status_q, status_d;
  skt_pkg::pos_t           fpos_q, fpos_d;
  skt_pkg::key_t           rkey_q, rkey_d;
  skt_pkg::pay_t           rpay_q, rpay_d;

  logic            key_lt, key_eq;
  logic            cnt_full, pos_bad;
  logic [AW-1:0]   pos_a;
  logic [XW-1:0]   cnt_x, idx_p1, idx_p2, pos_p1;

  // shared comparator
  assign key_lt = key_q < mem_rkey_i;
  assign key_eq = key_q == mem_rkey_i;

  assign cnt_full = count_q == CW'(DEPTH);
  assign pos_bad  = CMPW'(pos_q) >= CMPW'(count_q);
  assign pos_a    = AW'(pos_q);
  assign cnt_x    = XW'(count_q);
  assign idx_p1   = XW'(idx_q) + XW'(1);
  assign idx_p2   = XW'(idx_q) + XW'(2);
  assign pos_p1   = XW'(pos_a) + XW'(1);

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    key_d       = key_q;
    pay_d       = pay_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    count_d     = count_q;
    status_d    = status_q;
    fpos_d      = fpos_q;
    rkey_d      = rkey_q;
    rpay_d      = rpay_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wkey_o  = key_q;
    mem_wpay_o  = pay_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          kind_d  = req_i.kind;
          key_d   = KEY_BITS'(req_i.name_key);
          pay_d   = PAYLOAD_BITS'(req_i.entry_payload);
          pos_d   = req_i.position;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        status_d = skt_pkg::ST_OK;
        fpos_d   = '0;
        rkey_d   = '0;
        rpay_d   = '0;
        state_d  = S_RESULT;
        unique case (kind_q)
          skt_pkg::KIND_CLEAR: count_d = '0;
          skt_pkg::KIND_INSERT: begin
            if (cnt_full) begin
              status_d = skt_pkg::ST_FULL;
            end else if (count_q == '0) begin
              idx_d   = '0;
              state_d = S_INS_PUT;
            end else begin
              mem_re_o    = 1'b1;
              mem_raddr_o = AW'(count_q - CW'(1));
              idx_d       = AW'(count_q);
              state_d     = S_INS_CMP;
            end
          end
          skt_pkg::KIND_FIND: begin
            if (count_q == '0) begin
              status_d = skt_pkg::ST_MISS;
            end else begin
              mem_re_o    = 1'b1;
              mem_raddr_o = '0;
              idx_d       = '0;
              state_d     = S_FIND_CMP;
            end
          end
          skt_pkg::KIND_READ: begin
            if (pos_bad) begin
              status_d = skt_pkg::ST_BADPOS;
            end else begin
              mem_re_o    = 1'b1;
              mem_raddr_o = pos_a;
              state_d     = S_READ_WAIT;
            end
          end
          skt_pkg::KIND_OVERWRITE: begin
            if (pos_bad) begin
              status_d = skt_pkg::ST_BADPOS;
            end else begin
              mem_we_o    = 1'b1;
              mem_waddr_o = pos_a;
            end
          end
          skt_pkg::KIND_DELETE: begin
            if (pos_bad) begin
              status_d = skt_pkg::ST_BADPOS;
            end else if (pos_p1 >= cnt_x) begin
              count_d = count_q - CW'(1);
            end else begin
              mem_re_o    = 1'b1;
              mem_raddr_o = AW'(pos_p1);
              idx_d       = pos_a;
              state_d     = S_DEL_MOVE;
            end
          end
          default: ;
        endcase
      end
      S_INS_CMP: begin
        // read data holds entry idx-1
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q;
        if (key_lt) begin
          mem_wkey_o = mem_rkey_i;
          mem_wpay_o = mem_rpay_i;
          if (idx_q == AW'(1)) begin
            idx_d   = '0;
            state_d = S_INS_PUT;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = AW'(XW'(idx_q) - XW'(2));
            idx_d       = idx_q - AW'(1);
          end
        end else begin
          count_d = count_q + CW'(1);
          state_d = S_RESULT;
        end
      end
      S_INS_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q;
        count_d     = count_q + CW'(1);
        state_d     = S_RESULT;
      end
      S_FIND_CMP: begin
        if (key_eq) begin
          fpos_d  = skt_pkg::pos_t'(idx_q);
          rkey_d  = skt_pkg::key_t'(mem_rkey_i);
          rpay_d  = skt_pkg::pay_t'(mem_rpay_i);
          state_d = S_RESULT;
        end else if (idx_p1 >= cnt_x) begin
          status_d = skt_pkg::ST_MISS;
          state_d  = S_RESULT;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = AW'(idx_p1);
          idx_d       = AW'(idx_p1);
        end
      end
      S_READ_WAIT: begin
        fpos_d  = pos_q;
        rkey_d  = skt_pkg::key_t'(mem_rkey_i);
        rpay_d  = skt_pkg::pay_t'(mem_rpay_i);
        state_d = S_RESULT;
      end
      S_DEL_MOVE: begin
        // read data holds entry idx+1
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q;
        mem_wkey_o  = mem_rkey_i;
        mem_wpay_o  = mem_rpay_i;
        if (idx_p2 >= cnt_x) begin
          count_d = count_q - CW'(1);
          state_d = S_RESULT;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = AW'(idx_p2);
          idx_d       = AW'(idx_p1);
        end
      end
      S_RESULT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      kind_q   <= '0;
      key_q    <= '0;
      pay_q    <= '0;
      pos_q    <= '0;
      idx_q    <= '0;
      count_q  <= '0;
      status_q <= skt_pkg::ST_OK;
      fpos_q   <= '0;
      rkey_q   <= '0;
      rpay_q   <= '0;
    end else begin
      state_q  <= state_d;
      kind_q   <= kind_d;
      key_q    <= key_d;
      pay_q    <= pay_d;
      pos_q    <= pos_d;
      idx_q    <= idx_d;
      count_q  <= count_d;
      status_q <= status_d;
      fpos_q   <= fpos_d;
      rkey_q   <= rkey_d;
      rpay_q   <= rpay_d;
    end
  end

  assign req_ready_o = state_q == S_IDLE;
  assign res_valid_o = state_q == S_RESULT;

  always_comb begin
    res_o.status         = status_q;
    res_o.found_position = fpos_q;
    res_o.read_key       = rkey_q;
    res_o.read_payload   = rpay_q;
    res_o.entry_count    = skt_pkg::count_t'(count_q);
  end

  `SKT_ASSERT_IMP(a_count_max, 1'b1, count_q <= CW'(DEPTH), "entry count above depth")
  `SKT_ASSERT_IMP(a_port_clash, mem_we_o && mem_re_o, mem_waddr_o != mem_raddr_o, "rd/wr clash")
  `SKT_ASSERT_IMP(a_full_flag, res_valid_o && status_q == skt_pkg::ST_FULL, cnt_full, "bad full")
  `SKT_ASSERT_NXT(a_count_step, 1'b1, (count_q == $past(count_q)) || (count_q == '0) || (count_q == $past(count_q) + CW'(1)) || (count_q == $past(count_q) - CW'(1)), "count jump")

endmodule

/* sv/sorted_key_table.sv */
// ----------------------------------------------------------------------------
// sorted_key_table - bounded table of entries in ascending key order
// Requests come in on the in channel (valid/stall) and each one returns a
// single result item on the out channel. in_stall_o is high while a request
// is in work; one request is processed at a time.
// The path taken depends on the kind: clear, overwrite, bad position, full
// and unused kinds go straight to the result; read waits on one memory
// read; find walks up from entry 0 to the matching position; insert shifts
// the entries with larger keys up by one; delete shifts the entries above
// the position down by one.
// The walk is set by the entry memory's one read port and one write port:
// at most one entry read and one entry written per cycle through one key comparator.
// The next request is taken the cycle after the result moves into the
// output register.
// A result held by out_stall_i stays unchanged in the output register; the
// table takes and works on the next request meanwhile, and holds its own
// result until the output register frees.
// Reset empties the table (entry count zero); entry storage is not cleared.
// ----------------------------------------------------------------------------
module sorted_key_table #(
  parameter int DEPTH        = 32,
  parameter int KEY_BITS     = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  skt_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output skt_pkg::out_item_t  out_item_o
);

  localparam int AW = $clog2(DEPTH);

  logic                    req_ready;
  logic                    res_valid, slot_free;
  skt_pkg::out_item_t      res_item;
  logic                    out_valid_q, out_valid_d;
  skt_pkg::out_item_t      out_item_q, out_item_d;

  logic                    mem_we, mem_re;
  logic [AW-1:0]           mem_waddr, mem_raddr;
  logic [KEY_BITS-1:0]     mem_wkey, mem_rkey;
  logic [PAYLOAD_BITS-1:0] mem_wpay, mem_rpay;

  skt_ctrl #(
    .DEPTH        (DEPTH),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (req_ready),
    .req_i       (in_item_i),
    .res_valid_o (res_valid),
    .res_ready_i (slot_free),
    .res_o       (res_item),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wkey_o  (mem_wkey),
    .mem_wpay_o  (mem_wpay),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rkey_i  (mem_rkey),
    .mem_rpay_i  (mem_rpay)
  );

  skt_mem #(
    .DEPTH        (DEPTH),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wkey_i  (mem_wkey),
    .wpay_i  (mem_wpay),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rkey_o  (mem_rkey),
    .rpay_o  (mem_rpay)
  );

  assign in_stall_o = !req_ready;
  assign slot_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (res_valid && slot_free) begin
      out_valid_d = 1'b1;
      out_item_d  = res_item;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
